// ===== rtl/cbv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbv_pkg
// Shared types and constants of the cubic bend velocity sequencer.
// ----------------------------------------------------------------------------
package cbv_pkg;

  localparam int DIV_W = 40;   // dividend and quotient width of the divider
  localparam int DSR_W = 16;   // divisor width

  // phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_FWD  = 2'd1;
  localparam logic [1:0] PH_BENT = 2'd2;
  localparam logic [1:0] PH_BACK = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_DIST  = 3'd0;
  localparam logic [2:0] REG_TIME  = 3'd1;
  localparam logic [2:0] REG_BENT  = 3'd2;
  localparam logic [2:0] REG_HOME  = 3'd3;
  localparam logic [2:0] REG_CLEAR = 3'd4;
  localparam logic [2:0] REG_GAIN  = 3'd5;

  // datapath step codes
  localparam logic [3:0] ST_NONE  = 4'd0;
  localparam logic [3:0] ST_LATCH = 4'd1;
  localparam logic [3:0] ST_EVAL  = 4'd2;
  localparam logic [3:0] ST_S     = 4'd3;
  localparam logic [3:0] ST_MUL1  = 4'd4;
  localparam logic [3:0] ST_MUL2  = 4'd5;
  localparam logic [3:0] ST_MUL3  = 4'd6;
  localparam logic [3:0] ST_MUL4  = 4'd7;
  localparam logic [3:0] ST_MUL5  = 4'd8;
  localparam logic [3:0] ST_FINAL = 4'd9;

  // divider operand select
  localparam logic DSEL_TIME = 1'b0;
  localparam logic DSEL_VEL  = 1'b1;

  typedef struct packed {
    logic [3:0] step;
    logic       div_start;
    logic       div_sel;
  } cbv_cmd_t;

  typedef struct packed {
    logic fwd;
    logic t_ok;
    logic div_done;
  } cbv_stat_t;

endpackage
`default_nettype wire

// ===== rtl/cubic_bend_velocity_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bend_velocity_sequencer
// Four-phase bend sequencer with cubic-profile velocity command.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one beat per control tick (button_n, measured_position, now_ms).
//   out_*  : one beat per input beat (velocity_command, command_valid, phase).
//   cfg_*  : register writes, index 0..5, always ready; write only when idle.
// Sequence: each accepted tick is captured and the phase is updated; a tick
//   outside the forward move or past the move time then goes to the output
//   register. While bending forward, two 40-step divisions (normalized time,
//   then velocity scaling by the move time) on the shared one-bit-per-cycle divider run first.
// Throughput: one tick at a time; in_tready rises again once the result has
//   been moved into the output register.
// Reset (rst_n low, synchronous): phase idle, registers at their defaults,
//   no output beat pending.
// Stall: a result waits in the output register while out_tready is low; the
//   next tick is taken and worked on, but its result holds until the register
//   frees.
// ----------------------------------------------------------------------------
module cubic_bend_velocity_sequencer import cbv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [0] button_n, [24:1] measured_position, [56:25] now_ms, [63:57] zero
  input  wire logic [63:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] velocity_command, [32] command_valid, [34:33] phase, [39:35] zero
  output logic [39:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  cbv_cmd_t    cmd;
  cbv_stat_t   stat;
  logic        idle, load_out, in_fire, out_free;
  logic [31:0] res_cmd;
  logic        res_valid;
  logic [1:0]  res_phase;
  logic        out_tvalid_r;
  logic [39:0] out_tdata_r;

  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign cfg_ready = 1'b1;

  cbv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle),
    .load_out (load_out)
  );

  cbv_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid),
    .cfg_idx     (cfg_index),
    .cfg_val     (cfg_data),
    .in_button_n (in_tdata[0]),
    .in_pos      (in_tdata[24:1]),
    .in_now      (in_tdata[56:25]),
    .cmd         (cmd),
    .stat        (stat),
    .res_cmd     (res_cmd),
    .res_valid   (res_valid),
    .res_phase   (res_phase)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_tdata_r <= {5'd0, res_phase, res_valid, res_cmd};
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // a command is only flagged while bending forward
  a_valid_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[34:33] == PH_FWD)
    else $error("command_valid outside forward phase");

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !out_tvalid_r || out_tready)
    else $error("output register overwritten");

  // one tick at a time
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input taken while busy");

  // no command without a valid flag
  a_zero_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[31:0] == 32'd0)
    else $error("nonzero command without valid");

endmodule
`default_nettype wire

// ===== rtl/cbv_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbv_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbv_div import cbv_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DSR_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DSR_W:0]   rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DSR_W:0]   trial;
  logic [DSR_W+1:0] diff;

  assign trial = {rem_r[DSR_W-1:0], quo_r[DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      if (!diff[DSR_W+1]) begin
        rem_r <= diff[DSR_W:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/cbv_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbv_dp
// Datapath: configuration, phase state, cubic profile and command arithmetic.
// ----------------------------------------------------------------------------
module cbv_dp import cbv_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx,
  input  wire logic [23:0]        cfg_val,
  input  wire logic               in_button_n,
  input  wire logic signed [23:0] in_pos,
  input  wire logic [31:0]        in_now,
  input  wire cbv_cmd_t           cmd,
  output cbv_stat_t               stat,
  output logic [31:0]             res_cmd,
  output logic                    res_valid,
  output logic [1:0]              res_phase
);

  // configuration
  logic signed [23:0] dist_r, bent_r, home_r;
  logic [15:0]        time_r, gain_r;
  logic [19:0]        clear_r;

  // state
  logic [1:0]         phase_r;
  logic signed [23:0] start_pos_r;
  logic [31:0]        mstart_r;

  // captured tick
  logic               btn_r;
  logic signed [23:0] pos_r;
  logic [31:0]        now_r;

  // work registers
  logic               fwd_r, tok_r;
  logic [15:0]        t_r;
  logic [16:0]        s_r, p_r, g_r;
  logic [33:0]        s2_r, sg_r;
  logic signed [41:0] dp_r;
  logic [40:0]        ag_r;
  logic [54:0]        an_r;
  logic               dneg_r;
  logic signed [26:0] desired_r;
  logic signed [44:0] ep_r;
  logic [31:0]        cmd_r;

  // divider
  logic             div_done;
  logic [DIV_W-1:0] div_q, div_a;
  logic [15:0]      tt;

  assign tt    = (time_r == 16'd0) ? 16'd1 : time_r;
  assign div_a = (cmd.div_sel == DSEL_TIME) ? {8'd0, t_r, 16'd0} : {1'b0, an_r[54:16]};

  cbv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (tt),
    .done     (div_done),
    .quotient (div_q)
  );

  // phase transition
  logic signed [25:0] c_s, bt_s, ht_s, p_s;
  logic               in_bent, in_home, pressed;
  logic [1:0]         phase_nxt;
  logic [31:0]        t_full;

  assign c_s     = {6'd0, clear_r};
  assign bt_s    = 26'(bent_r);
  assign ht_s    = 26'(home_r);
  assign p_s     = 26'(pos_r);
  assign in_bent = (p_s > bt_s - c_s) && (p_s < bt_s + c_s);
  assign in_home = (p_s > ht_s - c_s) && (p_s < ht_s + c_s);
  assign pressed = !btn_r;

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: if (pressed) phase_nxt = PH_FWD;
      PH_FWD:  if (in_bent) phase_nxt = PH_BENT;
      PH_BENT: if (pressed) phase_nxt = PH_BACK;
      PH_BACK: if (in_home) phase_nxt = PH_IDLE;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // entering the move means zero elapsed time
  assign t_full = (phase_r == PH_IDLE) ? 32'd0 : now_r - mstart_r;

  // final arithmetic
  logic signed [44:0] ep_adj;
  logic signed [28:0] corr;
  logic signed [41:0] vel, sum;
  logic signed [41:0] dp_adj;

  assign dp_adj = dp_r + (dp_r[41] ? 42'sd65535 : 42'sd0);
  assign ep_adj = ep_r + (ep_r[44] ? 45'sd65535 : 45'sd0);
  assign corr   = 29'(ep_adj >>> 16);
  assign vel    = dneg_r ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
  assign sum    = vel + 42'(corr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r      <= 24'sd200000;
      time_r      <= 16'd3000;
      bent_r      <= 24'sd250880;
      home_r      <= 24'sd0;
      clear_r     <= 20'd10000;
      gain_r      <= 16'd6554;
      phase_r     <= PH_IDLE;
      start_pos_r <= '0;
      mstart_r    <= '0;
      fwd_r       <= 1'b0;
      tok_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_DIST:  dist_r  <= cfg_val;
          REG_TIME:  time_r  <= cfg_val[15:0];
          REG_BENT:  bent_r  <= cfg_val;
          REG_HOME:  home_r  <= cfg_val;
          REG_CLEAR: clear_r <= cfg_val[19:0];
          REG_GAIN:  gain_r  <= cfg_val[15:0];
          default: ;
        endcase
      end
      if (cmd.step == ST_EVAL) begin
        phase_r <= phase_nxt;
        if (phase_r == PH_IDLE && pressed) begin
          start_pos_r <= pos_r;
          mstart_r    <= now_r;
        end
        fwd_r <= (phase_nxt == PH_FWD);
        tok_r <= (t_full <= {16'd0, tt});
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.step)
      ST_LATCH: begin
        btn_r <= in_button_n;
        pos_r <= in_pos;
        now_r <= in_now;
      end
      ST_EVAL: begin
        t_r   <= t_full[15:0];
        cmd_r <= '0;
      end
      ST_S: s_r <= div_q[16:0];
      ST_MUL1: begin
        s2_r <= 34'(s_r) * 34'(s_r);
        sg_r <= 34'(s_r) * 34'(17'd65536 - s_r);
      end
      ST_MUL2: begin
        p_r <= 17'((52'(s2_r) * 52'(18'd196608 - {s_r, 1'b0})) >> 32);
        g_r <= 17'((37'(sg_r) * 37'd6) >> 16);
      end
      ST_MUL3: begin
        dp_r   <= 42'(dist_r) * $signed({25'd0, p_r});
        // magnitude of the distance, zero-extended
        ag_r   <= 41'($unsigned(dist_r[23] ? 24'(-dist_r) : dist_r)) * 41'(g_r);
        dneg_r <= dist_r[23];
      end
      ST_MUL4: begin
        desired_r <= 27'(start_pos_r) + 27'(dp_adj >>> 16);
        an_r      <= 55'(ag_r) * 55'd10000;
      end
      ST_MUL5: ep_r <= $signed({29'd0, gain_r}) * 45'(desired_r - 27'(pos_r));
      ST_FINAL: begin
        if (sum > 42'sd2147483647)       cmd_r <= 32'h7fffffff;
        else if (sum < -42'sd2147483648) cmd_r <= 32'h80000000;
        else                             cmd_r <= sum[31:0];
      end
      default: ;
    endcase
  end

  assign stat.fwd      = fwd_r;
  assign stat.t_ok     = tok_r;
  assign stat.div_done = div_done;
  assign res_cmd       = cmd_r;
  assign res_valid     = fwd_r;
  assign res_phase     = phase_r;

endmodule
`default_nettype wire

// ===== rtl/cbv_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbv_ctrl
// Sequencer for one tick: capture, phase update, division, multiplies.
// ----------------------------------------------------------------------------
module cbv_ctrl import cbv_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_fire,
  input  wire logic      out_free,
  input  wire cbv_stat_t stat,
  output cbv_cmd_t       cmd,
  output logic           idle,
  output logic           load_out
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVAL  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_WAIT1 = 4'd3;
  localparam logic [3:0] S_M1    = 4'd4;
  localparam logic [3:0] S_M2    = 4'd5;
  localparam logic [3:0] S_M3    = 4'd6;
  localparam logic [3:0] S_M4    = 4'd7;
  localparam logic [3:0] S_M5    = 4'd8;
  localparam logic [3:0] S_WAIT2 = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.step      = ST_NONE;
    cmd.div_start = 1'b0;
    cmd.div_sel   = DSEL_TIME;
    load_out      = 1'b0;
    case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.step  = ST_LATCH;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.step  = ST_EVAL;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.fwd && stat.t_ok) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_WAIT1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WAIT1: if (stat.div_done) begin
        cmd.step  = ST_S;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.step  = ST_MUL1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.step  = ST_MUL2;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.step  = ST_MUL3;
        state_nxt = S_M4;
      end
      S_M4: begin
        cmd.step  = ST_MUL4;
        state_nxt = S_M5;
      end
      S_M5: begin
        // velocity division runs beside the correction multiply
        cmd.step      = ST_MUL5;
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_VEL;
        state_nxt     = S_WAIT2;
      end
      S_WAIT2: begin
        cmd.div_sel = DSEL_VEL;
        if (stat.div_done) begin
          cmd.step  = ST_FINAL;
          state_nxt = S_DONE;
        end
      end
      S_DONE: if (out_free) begin
        load_out  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign idle = (state_r == S_IDLE);

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the cubic bend velocity sequencer against a cycle-free predictor of
// the phase sequencer and the cubic velocity command. Well-formed bend cycles
// and noise ticks run under several register settings. Random idle bursts
// occur on the input and output streams, except in the final quiet run.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cbv_pkg::*;

  typedef struct {
    bit               btn_n;
    bit signed [23:0] pos;
    bit [31:0]        now;
  } tick_t;

  typedef struct {
    bit [31:0] vel;
    bit        vld;
    bit [1:0]  ph;
  } command_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  tick_t    pending_ticks[$];
  command_t expected_cmds[$];
  int       errors = 0;
  bit       quiet = 1'b0;
  int       in_gap = 0;
  int       out_stall = 0;

  // shadow registers and sequencer state
  bit signed [23:0] dist_q;
  bit [15:0]        time_q;
  bit signed [23:0] bent_q;
  bit signed [23:0] home_q;
  bit [19:0]        clear_q;
  bit [15:0]        gain_q;
  bit [1:0]         phase_q;
  bit signed [23:0] start_pos_q;
  bit [31:0]        start_ms_q;

  cubic_bend_velocity_sequencer dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit signed [23:0] clip24(longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  function automatic bit in_window(longint pos, bit signed [23:0] target);
    longint c;
    c = clear_q;
    return pos > longint'(target) - c && pos < longint'(target) + c;
  endfunction

  function automatic bit [31:0] bend_velocity(longint pos, bit [31:0] now);
    longint tt, t, s, p, g, d, desired, vel, corr, sum;
    bit [31:0] elapsed;
    tt = (time_q == 0) ? 1 : time_q;
    elapsed = now - start_ms_q;
    t = elapsed;
    if (t > tt) return 32'd0;
    s = (t << 16) / tt;
    p = (s * s * (196608 - 2 * s)) >>> 32;
    g = (6 * s * (65536 - s)) >>> 16;
    d = dist_q;
    desired = longint'(start_pos_q) + (d * p) / 65536;
    vel = (d * 10000 * g) / (65536 * tt);
    corr = (longint'(gain_q) * (desired - pos)) / 65536;
    sum = vel + corr;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  function automatic command_t step_sequencer(tick_t tk);
    command_t r;
    case (phase_q)
      PH_IDLE: if (!tk.btn_n) begin
        phase_q = PH_FWD;
        start_pos_q = tk.pos;
        start_ms_q = tk.now;
      end
      PH_FWD:  if (in_window(tk.pos, bent_q)) phase_q = PH_BENT;
      PH_BENT: if (!tk.btn_n) phase_q = PH_BACK;
      default: if (in_window(tk.pos, home_q)) phase_q = PH_IDLE;
    endcase
    r.vel = '0;
    r.vld = 1'b0;
    r.ph = phase_q;
    if (phase_q == PH_FWD) begin
      r.vel = bend_velocity(tk.pos, tk.now);
      r.vld = 1'b1;
    end
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    tick_t tk;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        tk = pending_ticks.pop_front();
        in_tdata <= {7'd0, tk.now, tk.pos, tk.btn_n};
        in_tvalid <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 6);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) out_stall = $urandom_range(1, 6);
    end
  end

  // monitor: register writes, accepted ticks, result beats
  always @(posedge clk) begin
    tick_t    tk;
    command_t exp_c;
    if (!rst_n) begin
      dist_q = 24'sd200000;
      time_q = 16'd3000;
      bent_q = 24'sd250880;
      home_q = 24'sd0;
      clear_q = 20'd10000;
      gain_q = 16'd6554;
      phase_q = PH_IDLE;
      start_pos_q = '0;
      start_ms_q = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIST:  dist_q = cfg_data;
          REG_TIME:  time_q = cfg_data[15:0];
          REG_BENT:  bent_q = cfg_data;
          REG_HOME:  home_q = cfg_data;
          REG_CLEAR: clear_q = cfg_data[19:0];
          REG_GAIN:  gain_q = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        tk.btn_n = in_tdata[0];
        tk.pos = in_tdata[24:1];
        tk.now = in_tdata[56:25];
        expected_cmds.push_back(step_sequencer(tk));
      end
      if (out_tvalid && out_tready) begin
        if (expected_cmds.size() == 0) begin
          $error("unexpected result beat %h", out_tdata);
          errors++;
        end else begin
          exp_c = expected_cmds.pop_front();
          if (out_tdata[31:0] !== exp_c.vel) begin
            $error("velocity_command: expected %0d, actual %0d",
                   $signed(exp_c.vel), $signed(out_tdata[31:0]));
            errors++;
          end
          if (out_tdata[32] !== exp_c.vld) begin
            $error("command_valid: expected %0d, actual %0d", exp_c.vld, out_tdata[32]);
            errors++;
          end
          if (out_tdata[34:33] !== exp_c.ph) begin
            $error("phase: expected %0d, actual %0d", exp_c.ph, out_tdata[34:33]);
            errors++;
          end
        end
      end
    end
  end

  task automatic add_tick(bit btn_n, longint pos, bit [31:0] now);
    tick_t tk;
    tk.btn_n = btn_n;
    tk.pos = clip24(pos);
    tk.now = now;
    pending_ticks.push_back(tk);
  endtask

  function automatic longint near_target(bit signed [23:0] target);
    int c;
    c = (clear_q == 0) ? 0 : clear_q - 1;
    return longint'(target) + $signed($urandom_range(0, 2 * c)) - c;
  endfunction

  function automatic longint rand_pos();
    return $signed(24'($urandom));
  endfunction

  // one full bend: press, follow the move, arrive, press, return home
  task automatic add_bend_cycle();
    bit [31:0] t0;
    longint    p0;
    int        span, n;
    span = (time_q == 0 ? 1 : time_q);
    span = span + span / 4 + 2;
    t0 = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, span) : $urandom;
    p0 = rand_pos();
    add_tick(1'b0, p0, t0);
    n = $urandom_range(2, 8);
    repeat (n) begin
      add_tick(1'($urandom_range(0, 1)),
               p0 + $signed($urandom_range(0, 1 << 21)) - (1 << 20),
               t0 + $urandom_range(0, span));
    end
    add_tick(1'($urandom_range(0, 1)), near_target(bent_q), t0 + $urandom_range(0, span));
    repeat ($urandom_range(1, 3)) add_tick(1'b1, rand_pos(), $urandom);
    add_tick(1'b0, rand_pos(), $urandom);
    repeat ($urandom_range(0, 2)) add_tick(1'($urandom_range(0, 1)), rand_pos(), $urandom);
    add_tick(1'($urandom_range(0, 1)), near_target(home_q), $urandom);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_ticks.size() > 0 || in_tvalid || expected_cmds.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_all(logic [23:0] d, logic [23:0] t, logic [23:0] b,
                           logic [23:0] h, logic [23:0] c, logic [23:0] g);
    write_reg(REG_DIST, d);
    write_reg(REG_TIME, t);
    write_reg(REG_BENT, b);
    write_reg(REG_HOME, h);
    write_reg(REG_CLEAR, c);
    write_reg(REG_GAIN, g);
  endtask

  initial begin
    int added;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // defaults: idle extremes, press at wrap, exact and past move end
    add_tick(1'b1, 8388607, 32'h0);
    add_tick(1'b1, -8388608, 32'hFFFF_FFFF);
    add_tick(1'b0, -8388608, 32'hFFFF_FFF0);
    add_tick(1'b0, 0, 32'd5);
    add_tick(1'b1, 8388607, 32'hFFFF_FFF0 + 3000);
    add_tick(1'b1, 100000, 32'hFFFF_FFF0 + 3001);
    add_tick(1'b1, 250880 + 9999, 32'd7);
    add_tick(1'b1, 0, 32'd8);
    add_tick(1'b0, 0, 32'd9);
    add_tick(1'b1, 10000, 32'd10);
    add_tick(1'b1, -9999, 32'd11);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        wait_drained();
        case (ph)
          1: write_all(-24'sd200000, 24'd40, -24'sd150000, 24'sd5000, 24'd20000, 24'd65535);
          2: write_all(24'h7FFFFF, 24'd1, 24'h7FFFFA, 24'h800005, 24'hFFFFF, 24'd0);
          3: write_all(24'h800000, 24'd65535, 24'd0, 24'd0, 24'd0, 24'd32768);
          4: write_all(24'd300, 24'd0, 24'd1000, -24'sd1000, 24'd1, 24'd100);
          5: write_all(24'd123456, 24'd500, 24'($urandom), 24'($urandom), 24'd2000,
                       24'd6554);
          default: begin
            quiet = 1'b1;
            write_all(24'($urandom), 24'($urandom_range(1, 2000)), 24'($urandom),
                      24'($urandom), 24'($urandom_range(0, 1048575)),
                      24'($urandom_range(0, 65535)));
          end
        endcase
      end
      added = 0;
      while (added < 125) begin
        if ($urandom_range(0, 3) == 0) begin
          add_tick(1'($urandom_range(0, 1)), rand_pos(), $urandom);
          added++;
        end else begin
          n_before: begin
            int sz;
            sz = pending_ticks.size();
            add_bend_cycle();
            added += pending_ticks.size() - sz;
          end
        end
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
